// File: design/pfsw_pkg.sv
// Shared types, constants and helpers for the pixel fade/scale writer.
package pfsw_pkg;

   localparam int PixelStoreDepthDefault = 1024;

   localparam int IndexWidth = 10;
   localparam int ColorWidth = 32;
   localparam int CountWidth = 8;

   localparam logic [7:0] FadeStep   = 8'd12;
   localparam logic [6:0] FullPct    = 7'd100;
   localparam logic [7:0] ByteMask   = 8'hFF;
   // floor(x / 100) == (x * DivRecip) >> DivShift for every x <= 25500
   localparam logic [13:0] DivRecip  = 14'd10486;
   localparam int          DivShift  = 20;

   typedef enum logic [1:0] {
      STRIP_NONE = 2'd0,
      STRIP_RGB  = 2'd1,
      STRIP_RGBW = 2'd2,
      STRIP_EXT  = 2'd3
   } strip_kind_type;

   typedef enum logic [1:0] {
      CSR_STRIP_TYPE    = 2'd0,
      CSR_STATUS_COUNT  = 2'd1,
      CSR_FORWARD_COUNT = 2'd2,
      CSR_REAR_COUNT    = 2'd3
   } csr_index_type;

   localparam logic [1:0] SelStatus  = 2'd0;
   localparam logic [1:0] SelForward = 2'd1;
   localparam logic [1:0] SelRear    = 2'd2;

   typedef struct packed {
      logic [IndexWidth-1:0] pixel_index;
      logic [ColorWidth-1:0] target_color;
      logic [7:0]            brightness_pct;
      logic                  fade_enable;
   } req_type;

   typedef struct packed {
      logic [1:0]            strip_select;
      logic [7:0]            strip_position;
      logic [ColorWidth-1:0] local_color;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load_req;
      logic clear_start;
      logic clear_step;
      logic read;
      logic fade;
      logic scale;
      logic load_out;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic item_ok;
      logic spare_slot;
      logic clear_last;
      logic out_free;
   } status_type;

   function automatic logic [7:0] fade_channel(input logic [7:0] cur, input logic [7:0] tgt);
      logic [7:0] res;
      res = cur;
      if (cur < tgt) begin
         res = ((tgt - cur) <= FadeStep) ? tgt : cur + FadeStep;
      end else if (cur > tgt) begin
         res = ((cur - tgt) <= FadeStep) ? tgt : cur - FadeStep;
      end
      return res;
   endfunction

   function automatic logic [ColorWidth-1:0] fade_color(input logic [ColorWidth-1:0] from,
                                                        input logic [ColorWidth-1:0] to);
      logic [ColorWidth-1:0] res;
      for (int i = 0; i < 4; i++) begin
         res[i*8 +: 8] = fade_channel(from[i*8 +: 8], to[i*8 +: 8]);
      end
      return res;
   endfunction

endpackage

// File: design/pfsw_ram.sv
// Generic single-port-write, registered-read RAM.
module pfsw_ram #(
   parameter int Width = 32,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] waddr,
   input  logic [Width-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(Depth)-1:0] raddr,
   output logic [Width-1:0]         rdata
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: design/pfsw_ctrl.sv
// Sequencer for clearing, request intake, fade write-back and scaling.
module pfsw_ctrl import pfsw_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       cfg_write,
   input  status_type status,
   output cmd_type    cmd,
   output logic       req_ready
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_FADE,
      ST_SCALE,
      ST_OUT
   } state_type;

   state_type state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else if (cfg_write) begin
         state_ff <= ST_CLEAR;
      end else begin
         case (state_ff)
            ST_CLEAR: if (status.clear_last) state_ff <= ST_IDLE;
            ST_IDLE:  if (req_valid) state_ff <= ST_READ;
            ST_READ:  state_ff <= status.item_ok ? ST_FADE : ST_IDLE;
            ST_FADE:  state_ff <= status.spare_slot ? ST_IDLE : ST_SCALE;
            ST_SCALE: state_ff <= ST_OUT;
            ST_OUT:   if (status.out_free) state_ff <= ST_IDLE;
            default:  state_ff <= ST_CLEAR;
         endcase
      end
   end

   always_comb begin
      cmd             = '0;
      cmd.clear_start = cfg_write;
      if (!cfg_write) begin
         case (state_ff)
            ST_CLEAR: cmd.clear_step = 1'b1;
            ST_IDLE:  cmd.load_req   = req_valid;
            ST_READ:  cmd.read       = status.item_ok;
            ST_FADE:  cmd.fade       = 1'b1;
            ST_SCALE: cmd.scale      = 1'b1;
            ST_OUT:   cmd.load_out   = status.out_free;
            default:  cmd            = '0;
         endcase
      end
   end

   // a register write wins over intake, so no request is taken in that cycle
   assign req_ready = (state_ff == ST_IDLE) && !cfg_write;

endmodule

// File: design/pfsw_dp.sv
// Datapath: config registers, pixel store, fade, brightness scaling, routing.
module pfsw_dp import pfsw_pkg::*; #(
   parameter int PixelStoreDepth = PixelStoreDepthDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata,
   input  req_type    req_data,
   input  cmd_type    cmd,
   output status_type status,
   input  logic       rsp_stall,
   output logic       rsp_valid,
   output rsp_type    rsp_data
);

   localparam int AddrWidth = $clog2(PixelStoreDepth);

   strip_kind_type        strip_type_ff;
   logic [7:0]            status_count_ff;
   logic [7:0]            forward_count_ff;
   logic [7:0]            rear_count_ff;
   logic [IndexWidth-1:0] pixel_total;

   req_type               req_ff;
   logic [AddrWidth-1:0]  clr_cnt_ff;
   logic [ColorWidth-1:0] color_ff;
   logic [14:0]           prod_ff [4];
   logic                  rsp_valid_ff;
   rsp_type               rsp_data_ff;

   logic [AddrWidth-1:0]  req_addr;
   logic [ColorWidth-1:0] store_rdata;
   logic [ColorWidth-1:0] faded;
   logic                  ram_we;
   logic [AddrWidth-1:0]  ram_waddr;
   logic [ColorWidth-1:0] ram_wdata;
   logic [6:0]            pct;
   logic [7:0]            chan_q [4];
   logic [8:0]            fwd_end;
   logic [1:0]            sel_in;
   logic [7:0]            pos_in;
   logic [ColorWidth-1:0] local_in;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         strip_type_ff    <= STRIP_NONE;
         status_count_ff  <= '0;
         forward_count_ff <= '0;
         rear_count_ff    <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_STRIP_TYPE:    strip_type_ff    <= strip_kind_type'(csr_wdata[1:0]);
            CSR_STATUS_COUNT:  status_count_ff  <= csr_wdata;
            CSR_FORWARD_COUNT: forward_count_ff <= csr_wdata;
            CSR_REAR_COUNT:    rear_count_ff    <= csr_wdata;
            default:           strip_type_ff    <= strip_type_ff;
         endcase
      end
   end

   assign pixel_total = IndexWidth'({2'b00, status_count_ff} + {2'b00, forward_count_ff}
                                    + {2'b00, rear_count_ff} + 10'd1);

   // clear sweep
   always_ff @(posedge clock) begin
      if (reset || cmd.clear_start) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_cnt_ff <= clr_cnt_ff + AddrWidth'(1);
      end
   end

   assign status.clear_last = (clr_cnt_ff == AddrWidth'(PixelStoreDepth - 1));

   // request intake and checks
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
   end

   assign req_addr = AddrWidth'(req_ff.pixel_index);

   assign status.item_ok = ((strip_type_ff == STRIP_RGB) || (strip_type_ff == STRIP_RGBW))
                           && (req_ff.pixel_index < pixel_total)
                           && ({22'd0, req_ff.pixel_index} < 32'(PixelStoreDepth));
   assign status.spare_slot = (({1'b0, req_ff.pixel_index} + 11'd1) == {1'b0, pixel_total});

   // store
   assign faded     = req_ff.fade_enable ? fade_color(store_rdata, req_ff.target_color)
                                         : req_ff.target_color;
   assign ram_we    = cmd.clear_step || cmd.fade;
   assign ram_waddr = cmd.fade ? req_addr : clr_cnt_ff;
   assign ram_wdata = cmd.fade ? faded : '0;

   pfsw_ram #(
      .Width (ColorWidth),
      .Depth (PixelStoreDepth)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (cmd.read),
      .raddr (req_addr),
      .rdata (store_rdata)
   );

   // scaling: byte * pct, then divide by 100 through a reciprocal
   assign pct = (req_ff.brightness_pct > {1'b0, FullPct}) ? FullPct
                                                          : req_ff.brightness_pct[6:0];

   always_ff @(posedge clock) begin
      if (cmd.fade) begin
         color_ff <= faded;
      end
      if (cmd.scale) begin
         for (int i = 0; i < 4; i++) begin
            prod_ff[i] <= {7'd0, color_ff[i*8 +: 8]} * {8'd0, pct};
         end
      end
   end

   always_comb begin
      logic [28:0] wide;
      for (int i = 0; i < 4; i++) begin
         wide      = {14'd0, prod_ff[i]} * {15'd0, DivRecip};
         chan_q[i] = wide[DivShift +: 8];
      end
   end

   // chan_q index: 0 blue, 1 green, 2 red, 3 white
   assign local_in = (strip_type_ff == STRIP_RGBW)
                     ? {chan_q[1], chan_q[2], chan_q[0], chan_q[3]}
                     : {8'd0, chan_q[1], chan_q[2], chan_q[0]};

   // routing
   assign fwd_end = {1'b0, status_count_ff} + {1'b0, forward_count_ff};

   always_comb begin
      logic [9:0] pos_wide;
      if (req_ff.pixel_index < {2'b00, status_count_ff}) begin
         sel_in   = SelStatus;
         pos_wide = req_ff.pixel_index;
      end else if (req_ff.pixel_index < {1'b0, fwd_end}) begin
         sel_in   = SelForward;
         pos_wide = req_ff.pixel_index - {2'b00, status_count_ff};
      end else begin
         sel_in   = SelRear;
         pos_wide = req_ff.pixel_index - {1'b0, fwd_end};
      end
      pos_in = pos_wide[7:0];
   end

   // output register
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_data_ff.strip_select   <= sel_in;
         rsp_data_ff.strip_position <= pos_in;
         rsp_data_ff.local_color    <= local_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: design/pixel_fade_scale_writer.sv
// Top level of the pixel fade/scale writer.
//
// Usage:
//   req_*  : one pixel write per request (index, WRGB target, brightness %, fade).
//   rsp_*  : zero or one routed result per request (strip, position, GRB/GRBW color).
//   csr_*  : plain register write port; index 0 strip type, 1..3 strip counts.
//            Any register write restarts the store clear sweep.
// A request that yields a result passes the store read, fade + write-back,
//   multiply and divide into the output reg before it shows on rsp_valid.
// Requests are handled one at a time: a new one is taken only once the store
//   read-modify-write and, for a result, the two-step scaling of the last
//   one are through; dropped requests skip both, stored-only ones skip scaling.
//   The next request is taken while a result still waits in the output register.
// Reset and config writes: the pixel store is cleared one entry per cycle,
//   all PIXEL_STORE_DEPTH entries in turn, with req_stall high throughout.
// Receiver stall: the result holds in the output register; the block stalls
//   a further request only once its own result is ready and the register is full.
module pixel_fade_scale_writer import pfsw_pkg::*; #(
   parameter int PIXEL_STORE_DEPTH = PixelStoreDepthDefault
) (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   // result channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   // register write port
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;
   logic       req_ready;

   pfsw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .cfg_write (csr_we),
      .status    (status),
      .cmd       (cmd),
      .req_ready (req_ready)
   );

   pfsw_dp #(
      .PixelStoreDepth (PIXEL_STORE_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assign req_stall = !req_ready;

endmodule

// File: design/pfsw_checker.sv
// Port-level checks for the pixel fade/scale writer, bound to the top level.
module pfsw_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic csr_we
);

   // store clear sweep follows reset
   a_reset_clears: assert property (@(posedge clock) reset |=> req_stall)
      else $error("request taken right after reset");

   // one request at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken back to back");

   // register write starts a clear sweep
   a_csr_clears: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> req_stall)
      else $error("request taken right after register write");

   // a result appears only out of a busy interval
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result without work in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("stalled result dropped");

endmodule

bind pixel_fade_scale_writer pfsw_checker u_pfsw_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .csr_we    (csr_we)
);
